[design/ppm_p6_pkg.sv]
// ----------------------------------------------------------------------------
// ppm_p6_pkg
// Shared types and constants for the binary PPM (P6) stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_p6_pkg;

   // default limits
   localparam int MAX_DIM_DEF    = 4096;
   localparam int MAX_DIGITS_DEF = 10;

   // fixed width of the dimension fields in a result
   localparam int IMG_DIM_W = 13;

   // character codes
   localparam logic [7:0] CHAR_P   = 8'h50;
   localparam logic [7:0] CHAR_6   = 8'h36;
   localparam logic [7:0] DIGIT_LO = 8'h30;
   localparam logic [7:0] DIGIT_HI = 8'h39;
   localparam logic [7:0] ALPHA    = 8'hFF;
   localparam int         DEC_BASE = 10;

   // request kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // result status codes
   localparam logic [1:0] ST_PIXEL  = 2'd0;
   localparam logic [1:0] ST_HEADER = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [31:0]          pixel_word;
      logic [IMG_DIM_W-1:0] image_width;
      logic [IMG_DIM_W-1:0] image_height;
      logic                 last_pixel;
   } rsp_type;

   // result of one parse step
   typedef struct packed {
      logic    valid;
      rsp_type item;
   } res_type;

endpackage

`default_nettype wire

[design/ppm_p6_stream_to_argb.sv]
// ----------------------------------------------------------------------------
// ppm_p6_stream_to_argb
// Binary PPM (P6) byte stream to ARGB pixel stream.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while results are taken. A request is
// held in an input register, parsed in one pass of logic, and its result (if
// any) lands in the result register, so a byte's result passes through the
// input register and then the result register before it reaches the result
// channel. A stalled result holds the input register, which in turn holds off
// new requests; the result register is the single point that sets the rate. A
// header result carries width and height, each blue byte gives one 0xFF:R:G:B
// pixel, the final pixel has last_pixel set, and bad magic, empty or overlong
// fields and oversized dimensions give one error result, after which bytes are
// dropped until a restart request.
`default_nettype none

module ppm_p6_stream_to_argb #(
   parameter int MAX_DIM    = ppm_p6_pkg::MAX_DIM_DEF,
   parameter int MAX_DIGITS = ppm_p6_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire ppm_p6_pkg::req_type req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      ppm_p6_pkg::rsp_type rsp_data
);
   import ppm_p6_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    out_free;
   logic    step;
   logic    req_take;
   res_type res;

   // input register
   always_comb begin
      step      = in_valid_ff && out_free;
      req_ready = !in_valid_ff || step;
      req_take  = req_valid && req_ready;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else begin
         in_valid_in = in_valid_ff && !step;
         in_item_in  = in_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // parse step
   ppm_p6_parser #(
      .MAX_DIM    (MAX_DIM),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .res   (res)
   );

   // result register
   ppm_p6_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res       (res),
      .rsp_ready (rsp_ready),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // checks
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled request lost or changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_valid_ff)
      else $error("result or request present after reset");

   a_pixel_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_PIXEL |-> rsp_data.pixel_word[31:24] == ALPHA)
      else $error("pixel without opaque alpha");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      step && res.valid && res.item.status == ST_ERROR |=>
         rsp_valid && rsp_data.pixel_word == '0 && rsp_data.last_pixel == 1'b0)
      else $error("error result not delivered clean");

endmodule

`default_nettype wire

[design/ppm_p6_parser.sv]
// ----------------------------------------------------------------------------
// ppm_p6_parser
// Header state machine, decimal field accumulator and pixel packer. One
// request is consumed per step and yields at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_parser #(
   parameter int MAX_DIM    = ppm_p6_pkg::MAX_DIM_DEF,
   parameter int MAX_DIGITS = ppm_p6_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire ppm_p6_pkg::req_type item,
   output      ppm_p6_pkg::res_type res
);
   import ppm_p6_pkg::*;

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int ACC_SAT = MAX_DIM + 1;
   localparam int ACC_W   = $clog2(MAX_DIM + 2);
   localparam int SUM_W   = ACC_W + 4;
   localparam int DC_W    = $clog2(MAX_DIGITS + 1);
   localparam int PIX_W   = 2 * DIM_W;

   typedef enum logic [9:0] {
      PH_MAGIC_P    = 10'b00_0000_0001,
      PH_MAGIC_6    = 10'b00_0000_0010,
      PH_SKIP       = 10'b00_0000_0100,
      PH_WIDTH      = 10'b00_0000_1000,
      PH_HEIGHT_BEG = 10'b00_0001_0000,
      PH_HEIGHT     = 10'b00_0010_0000,
      PH_MAXV_BEG   = 10'b00_0100_0000,
      PH_MAXV       = 10'b00_1000_0000,
      PH_PIXELS     = 10'b01_0000_0000,
      PH_IDLE       = 10'b10_0000_0000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [DC_W-1:0]        dcount_ff, dcount_in;
   logic [DIM_W-1:0]       width_ff, width_in;
   logic [DIM_W-1:0]       height_ff, height_in;
   logic [PIX_W-1:0]       pix_left_ff, pix_left_in;
   logic [1:0]             byte_sel_ff, byte_sel_in;
   logic [7:0]             red_ff, red_in;
   logic [7:0]             green_ff, green_in;

   logic                   is_digit;
   logic [3:0]             digit_val;
   logic [SUM_W-1:0]       acc_wide;
   logic [ACC_W-1:0]       acc_sat;
   logic                   acc_too_big;
   logic                   digits_full;
   logic [IMG_DIM_W-1:0]   width_out;
   logic [IMG_DIM_W-1:0]   height_out;

   // digit decode and multiply-by-ten accumulate with saturation
   always_comb begin
      is_digit    = item.data_byte inside {[DIGIT_LO:DIGIT_HI]};
      digit_val   = 4'(item.data_byte - DIGIT_LO);
      acc_wide    = SUM_W'(acc_ff) * SUM_W'(DEC_BASE) + SUM_W'(digit_val);
      acc_sat     = (acc_wide > SUM_W'(ACC_SAT)) ? ACC_W'(ACC_SAT) : acc_wide[ACC_W-1:0];
      acc_too_big = acc_ff > ACC_W'(MAX_DIM);
      digits_full = dcount_ff >= DC_W'(MAX_DIGITS);
      width_out   = IMG_DIM_W'(width_ff);
      height_out  = IMG_DIM_W'(height_ff);
   end

   // next state and result
   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      dcount_in   = dcount_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      pix_left_in = pix_left_ff;
      byte_sel_in = byte_sel_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      res         = '0;

      if (step) begin
         if (item.kind == KIND_RESTART) begin
            phase_in = PH_MAGIC_P;
         end else begin
            case (phase_ff)
               PH_MAGIC_P: begin
                  if (item.data_byte != CHAR_P) begin
                     phase_in          = PH_IDLE;
                     res.valid         = 1'b1;
                     res.item.status   = ST_ERROR;
                  end else begin
                     phase_in = PH_MAGIC_6;
                  end
               end
               PH_MAGIC_6: begin
                  if (item.data_byte != CHAR_6) begin
                     phase_in          = PH_IDLE;
                     res.valid         = 1'b1;
                     res.item.status   = ST_ERROR;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  if (is_digit) begin
                     acc_in    = ACC_W'(digit_val);
                     dcount_in = DC_W'(1);
                     phase_in  = PH_WIDTH;
                  end
               end
               PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
                  if (is_digit) begin
                     if (digits_full) begin
                        phase_in        = PH_IDLE;
                        res.valid       = 1'b1;
                        res.item.status = ST_ERROR;
                     end else begin
                        acc_in    = acc_sat;
                        dcount_in = dcount_ff + DC_W'(1);
                     end
                  end else if (phase_ff == PH_MAXV) begin
                     // header complete: size the pixel count
                     pix_left_in           = PIX_W'(width_ff) * PIX_W'(height_ff);
                     byte_sel_in           = 2'd0;
                     phase_in              = (width_ff == '0 || height_ff == '0) ?
                                             PH_IDLE : PH_PIXELS;
                     res.valid             = 1'b1;
                     res.item.status       = ST_HEADER;
                     res.item.image_width  = width_out;
                     res.item.image_height = height_out;
                  end else if (acc_too_big) begin
                     phase_in        = PH_IDLE;
                     res.valid       = 1'b1;
                     res.item.status = ST_ERROR;
                  end else if (phase_ff == PH_WIDTH) begin
                     width_in = DIM_W'(acc_ff);
                     phase_in = PH_HEIGHT_BEG;
                  end else begin
                     height_in = DIM_W'(acc_ff);
                     phase_in  = PH_MAXV_BEG;
                  end
               end
               PH_HEIGHT_BEG, PH_MAXV_BEG: begin
                  if (!is_digit) begin
                     phase_in        = PH_IDLE;
                     res.valid       = 1'b1;
                     res.item.status = ST_ERROR;
                  end else begin
                     acc_in    = ACC_W'(digit_val);
                     dcount_in = DC_W'(1);
                     phase_in  = (phase_ff == PH_HEIGHT_BEG) ? PH_HEIGHT : PH_MAXV;
                  end
               end
               PH_PIXELS: begin
                  if (byte_sel_ff == 2'd0) begin
                     red_in      = item.data_byte;
                     byte_sel_in = 2'd1;
                  end else if (byte_sel_ff == 2'd1) begin
                     green_in    = item.data_byte;
                     byte_sel_in = 2'd2;
                  end else begin
                     // blue byte completes a pixel
                     byte_sel_in           = 2'd0;
                     pix_left_in           = pix_left_ff - PIX_W'(1);
                     if (pix_left_ff == PIX_W'(1)) begin
                        phase_in = PH_IDLE;
                     end
                     res.valid             = 1'b1;
                     res.item.status       = ST_PIXEL;
                     res.item.pixel_word   = {ALPHA, red_ff, green_ff, item.data_byte};
                     res.item.image_width  = width_out;
                     res.item.image_height = height_out;
                     res.item.last_pixel   = (pix_left_ff == PIX_W'(1));
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC_P;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // parse data registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      dcount_ff   <= dcount_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      pix_left_ff <= pix_left_in;
      byte_sel_ff <= byte_sel_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
   end

endmodule

`default_nettype wire

[design/ppm_p6_out_stage.sv]
// ----------------------------------------------------------------------------
// ppm_p6_out_stage
// Result register holding one finished result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire ppm_p6_pkg::res_type res,
   input  wire logic                rsp_ready,
   output      logic                out_free,
   output      logic                rsp_valid,
   output      ppm_p6_pkg::rsp_type rsp_data
);
   import ppm_p6_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   // slot is free when empty or draining this cycle
   always_comb begin
      out_free = !valid_ff || rsp_ready;
      load     = step && res.valid;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res.item;
      end else begin
         valid_in = valid_ff && !rsp_ready;
         data_in  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[tb/ppm_p6_stream_to_argb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_stream_to_argb_checker
// Watches both channels of the PPM P6 parser, runs its own copy of the parse
// on every accepted request and compares each result, field by field, with
// the oldest predicted one. Hands the failure count and the number of
// predicted results still outstanding to the testbench top.
// ----------------------------------------------------------------------------

module ppm_p6_stream_to_argb_checker #(
   parameter int MAX_DIM    = ppm_p6_pkg::MAX_DIM_DEF,
   parameter int MAX_DIGITS = ppm_p6_pkg::MAX_DIGITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  ppm_p6_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  ppm_p6_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending_count
);
   import ppm_p6_pkg::*;

   typedef enum logic [9:0] {
      PH_MAGIC_P    = 10'b00_0000_0001,
      PH_MAGIC_6    = 10'b00_0000_0010,
      PH_SKIP       = 10'b00_0000_0100,
      PH_WIDTH      = 10'b00_0000_1000,
      PH_HEIGHT_BEG = 10'b00_0001_0000,
      PH_HEIGHT     = 10'b00_0010_0000,
      PH_MAXV_BEG   = 10'b00_0100_0000,
      PH_MAXV       = 10'b00_1000_0000,
      PH_PIXELS     = 10'b01_0000_0000,
      PH_IDLE       = 10'b10_0000_0000
   } parse_phase_type;

   // parser state mirrored in variables wide enough for the block's values
   parse_phase_type       phase;
   logic [13:0]           acc;
   logic [3:0]            digit_cnt;
   logic [IMG_DIM_W-1:0]  width_v;
   logic [IMG_DIM_W-1:0]  height_v;
   logic [24:0]           px_left;
   logic [1:0]            byte_pos;
   logic [7:0]            red_v;
   logic [7:0]            green_v;

   // results the parser owes, oldest first
   rsp_type parsed_q[$];

   initial fail_count = 0;
   initial pending_count = 0;

   function automatic void clear_parser();
      phase     = PH_MAGIC_P;
      acc       = '0;
      digit_cnt = '0;
      width_v   = '0;
      height_v  = '0;
      px_left   = '0;
      byte_pos  = '0;
      red_v     = '0;
      green_v   = '0;
   endfunction

   // any format error: parse stops until restart
   function automatic rsp_type parse_error();
      rsp_type r;
      r = '0;
      r.status = ST_ERROR;
      phase = PH_IDLE;
      return r;
   endfunction

   // one request through the parse; has_rsp tells whether a result follows
   task automatic parse_byte(input req_type r, output bit has_rsp, output rsp_type res);
      logic [7:0] b;
      bit         dig;
      int         nxt;
      b = r.data_byte;
      dig = (b >= DIGIT_LO) && (b <= DIGIT_HI);
      has_rsp = 0;
      res = '0;
      if (r.kind == KIND_RESTART) begin
         clear_parser();
         return;
      end
      case (phase)
         PH_MAGIC_P: begin
            if (b != CHAR_P) begin
               has_rsp = 1;
               res = parse_error();
            end else
               phase = PH_MAGIC_6;
         end
         PH_MAGIC_6: begin
            if (b != CHAR_6) begin
               has_rsp = 1;
               res = parse_error();
            end else
               phase = PH_SKIP;
         end
         PH_SKIP: begin
            if (dig) begin
               acc = 14'(b - DIGIT_LO);
               digit_cnt = 4'd1;
               phase = PH_WIDTH;
            end
         end
         PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
            if (dig) begin
               if (int'(digit_cnt) >= MAX_DIGITS) begin
                  has_rsp = 1;
                  res = parse_error();
               end else begin
                  // accumulator saturates one above the largest dimension
                  digit_cnt = digit_cnt + 4'd1;
                  nxt = int'(acc) * DEC_BASE + int'(b - DIGIT_LO);
                  if (nxt > MAX_DIM + 1)
                     nxt = MAX_DIM + 1;
                  acc = 14'(nxt);
               end
            end else if (phase == PH_MAXV) begin
               // separator after maxval closes the header
               px_left = 25'(width_v) * 25'(height_v);
               byte_pos = 0;
               phase = (px_left == 0) ? PH_IDLE : PH_PIXELS;
               has_rsp = 1;
               res.status = ST_HEADER;
               res.image_width = width_v;
               res.image_height = height_v;
            end else if (int'(acc) > MAX_DIM) begin
               has_rsp = 1;
               res = parse_error();
            end else if (phase == PH_WIDTH) begin
               width_v = IMG_DIM_W'(acc);
               phase = PH_HEIGHT_BEG;
            end else begin
               height_v = IMG_DIM_W'(acc);
               phase = PH_MAXV_BEG;
            end
         end
         PH_HEIGHT_BEG, PH_MAXV_BEG: begin
            // a field must start right after its single separator
            if (!dig) begin
               has_rsp = 1;
               res = parse_error();
            end else begin
               acc = 14'(b - DIGIT_LO);
               digit_cnt = 4'd1;
               phase = (phase == PH_HEIGHT_BEG) ? PH_HEIGHT : PH_MAXV;
            end
         end
         PH_PIXELS: begin
            if (byte_pos == 0) begin
               red_v = b;
               byte_pos = 1;
            end else if (byte_pos == 1) begin
               green_v = b;
               byte_pos = 2;
            end else begin
               byte_pos = 0;
               px_left = px_left - 25'd1;
               if (px_left == 0)
                  phase = PH_IDLE;
               has_rsp = 1;
               res.status = ST_PIXEL;
               res.pixel_word = {ALPHA, red_v, green_v, b};
               res.image_width = width_v;
               res.image_height = height_v;
               res.last_pixel = (px_left == 0);
            end
         end
         default: ;
      endcase
   endtask

   // predict on accepted requests, compare on accepted results
   always @(posedge clock) begin : watch
      bit      has_rsp;
      rsp_type res;
      rsp_type want;
      if (reset) begin
         clear_parser();
         parsed_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data, has_rsp, res);
            if (has_rsp)
               parsed_q.push_back(res);
         end
         if (rsp_valid && rsp_ready) begin
            if (parsed_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result with nothing expected: status=%0d px=%h w=%0d h=%0d last=%b",
                           $realtime, rsp_data.status, rsp_data.pixel_word,
                           rsp_data.image_width, rsp_data.image_height,
                           rsp_data.last_pixel);
               fail_count = fail_count + 1;
            end else begin
               want = parsed_q.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.pixel_word !== want.pixel_word ||
                   rsp_data.image_width !== want.image_width ||
                   rsp_data.image_height !== want.image_height ||
                   rsp_data.last_pixel !== want.last_pixel) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch: expected status=%0d px=%h w=%0d h=%0d last=%b,",
                               " got status=%0d px=%h w=%0d h=%0d last=%b"},
                              $realtime, want.status, want.pixel_word, want.image_width,
                              want.image_height, want.last_pixel, rsp_data.status,
                              rsp_data.pixel_word, rsp_data.image_width,
                              rsp_data.image_height, rsp_data.last_pixel);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending_count <= parsed_q.size();
   end

endmodule

[tb/ppm_p6_stream_to_argb_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_stream_to_argb_tb
// Feeds the PPM P6 parser with whole image files: a directed set covering
// magic errors, empty, overlong and oversized fields, zero and largest
// dimensions, restarts and bytes after the end, a long result stall, then
// random files, mostly well formed with random content and some broken.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module ppm_p6_stream_to_argb_tb;
   import ppm_p6_pkg::*;

   localparam int RAND_ITEMS  = 330;
   localparam int LONG_HOLD   = 200;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent = 0;
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;

   // bytes of the file being built
   logic [7:0] file_bytes[$];

   always #5 clock = ~clock;

   ppm_p6_stream_to_argb DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ppm_p6_stream_to_argb_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // offer one request, with an optional gap first, and wait for acceptance
   task automatic send_req(input logic kind, input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: kind, data_byte: b};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i])
         send_req(KIND_DATA, file_bytes[i]);
      file_bytes.delete();
   endtask

   task automatic send_restart();
      send_req(KIND_RESTART, 8'($urandom_range(0, 255)));
   endtask

   task automatic add_text(input string t);
      foreach (t[i])
         file_bytes.push_back(t[i]);
   endtask

   // any non-digit, whitespace more often than not
   function automatic logic [7:0] pick_sep();
      logic [7:0] b;
      case ($urandom_range(0, 5))
         0: b = 8'h20;
         1: b = 8'h0A;
         2: b = 8'h09;
         3: b = 8'h0D;
         default: begin
            do b = 8'($urandom_range(0, 255));
            while (b >= DIGIT_LO && b <= DIGIT_HI);
         end
      endcase
      return b;
   endfunction

   // decimal field, now and then with leading zeros up to or past the limit
   task automatic add_field(input longint unsigned v);
      string s;
      int    pad;
      s = $sformatf("%0d", v);
      pad = 0;
      if ($urandom_range(0, 5) == 0)
         pad = $urandom_range(0, MAX_DIGITS_DEF - s.len());
      else if ($urandom_range(0, 40) == 0)
         pad = MAX_DIGITS_DEF + 1 - s.len();
      repeat (pad) file_bytes.push_back(DIGIT_LO);
      add_text(s);
   endtask

   // well-formed file with random separators and pixel bytes
   task automatic build_image(input int w, input int h, input longint unsigned maxv);
      file_bytes.push_back(CHAR_P);
      file_bytes.push_back(CHAR_6);
      repeat ($urandom_range(1, 3)) file_bytes.push_back(pick_sep());
      add_field(64'(w));
      file_bytes.push_back(pick_sep());
      add_field(64'(h));
      file_bytes.push_back(pick_sep());
      add_field(maxv);
      file_bytes.push_back(pick_sep());
      repeat (w * h * 3) file_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
            hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else
            rsp_ready <= 1'b1;
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ppm_p6_stream_to_argb_tb: FAIL");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int w;
      int h;
      int idx;
      int rand_start;
      longint unsigned maxv;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // smallest tall image with extreme pixel bytes, then bytes after the end
      add_text("P6 1 2 255\n");
      repeat (3) file_bytes.push_back(8'h00);
      repeat (3) file_bytes.push_back(8'hFF);
      add_text("P6 7");
      send_file();

      // largest width and largest height with a zero other side
      send_restart();
      add_text("P6\t4096\n0\n1\nxyz");
      send_file();
      send_restart();
      add_text("P6 0 4096 1 ");
      send_file();

      // dimension too large, then ignored bytes
      send_restart();
      add_text("P6 4097 1 1 P6 1 1 1 ");
      send_file();
      send_restart();
      add_text("P6 99999 1 1 ");
      send_file();
      send_restart();
      add_text("P6 1 5000 1 ");
      send_file();

      // separator boundaries, ten-digit fields
      send_restart();
      add_text("P6");
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h2F);
      file_bytes.push_back(8'h3A);
      add_text("0000000003");
      file_bytes.push_back(8'h2F);
      add_text("1");
      file_bytes.push_back(8'h3A);
      add_text("9999999999");
      file_bytes.push_back(8'hFF);
      repeat (9) file_bytes.push_back(8'($urandom_range(0, 255)));
      send_file();

      // too many digits
      send_restart();
      add_text("P6 12345678901 ");
      send_file();

      // empty height field, empty maxval field
      send_restart();
      add_text("P6 2  2 ");
      send_file();
      send_restart();
      add_text("P6 2 2  255 ");
      send_file();

      // bad magic on either byte
      send_restart();
      add_text("Q6 1 1 1 ");
      send_file();
      send_restart();
      add_text("P5 1 1 1 ");
      send_file();

      // restart in the middle of the pixels
      send_restart();
      add_text("P6 2 2 255\n");
      repeat (5) file_bytes.push_back(8'($urandom_range(0, 255)));
      send_file();
      send_restart();
      add_text("P6 1 1 1\n");
      repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
      send_file();

      // long result stall while pixels keep coming
      send_restart();
      add_text("P6 4 3 255\n");
      send_file();
      hold_req = 1'b1;
      repeat (36) file_bytes.push_back(8'($urandom_range(0, 255)));
      send_file();

      // random files
      rand_start = items_sent;
      while (items_sent - rand_start < RAND_ITEMS) begin
         idle_on = (items_sent - rand_start < RAND_ITEMS * 3 / 4) &&
                   ($urandom_range(0, 3) != 0);
         send_restart();
         case ($urandom_range(0, 19))
            0: begin
               w = $urandom_range(MAX_DIM_DEF + 1, 99999);
               h = 1;
            end
            1: begin
               w = 1;
               h = $urandom_range(MAX_DIM_DEF + 1, 99999);
            end
            2, 3: begin
               w = $urandom_range(0, MAX_DIM_DEF);
               h = 0;
            end
            4: begin
               w = 0;
               h = $urandom_range(0, MAX_DIM_DEF);
            end
            default: begin
               w = $urandom_range(1, 4);
               h = $urandom_range(1, 4);
            end
         endcase
         maxv = ($urandom_range(0, 3) == 0) ? 64'd9999999999 :
                                              64'($urandom_range(1, 65535));
         if (w > MAX_DIM_DEF || h > MAX_DIM_DEF)
            build_image(1, 1, maxv);
         else
            build_image(w, h, maxv);
         if (w > MAX_DIM_DEF || h > MAX_DIM_DEF) begin
            // replace the header with an oversized one
            file_bytes.delete();
            add_text($sformatf("P6 %0d %0d 255 ", w, h));
         end
         idx = $urandom_range(0, file_bytes.size() - 1);
         case ($urandom_range(0, 7))
            0: file_bytes[idx] = 8'($urandom_range(0, 255));
            1: file_bytes.insert(idx, pick_sep());
            2: while (file_bytes.size() > idx + 1) void'(file_bytes.pop_back());
            3: begin
               // noise, biased toward magic and digits
               file_bytes.delete();
               repeat ($urandom_range(1, 24)) begin
                  case ($urandom_range(0, 3))
                     0: file_bytes.push_back(CHAR_P);
                     1: file_bytes.push_back(CHAR_6);
                     2: file_bytes.push_back(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
                     default: file_bytes.push_back(8'($urandom_range(0, 255)));
                  endcase
               end
            end
            4: repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
            default: ;
         endcase
         send_file();
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("ppm_p6_stream_to_argb_tb: PASS");
      else
         $display("ppm_p6_stream_to_argb_tb: FAIL");
      $finish;
   end

endmodule
